@@ rtl/wpfs_pkg.sv @@
package wpfs_pkg;
    localparam int CoordW = 32;
    localparam int DiffW  = 33;
    localparam int MagW   = 33;
    localparam int SumW   = 67;
    localparam int RootW  = 34;
    localparam int NumW   = 48;
    localparam int VelW   = 16;

    localparam logic [1:0] RegPathCount = 2'd0;
    localparam logic [1:0] RegReach     = 2'd1;
    localparam logic [1:0] RegSlow      = 2'd2;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActSteer = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_REACH = 10'b0000000100,
        S_PICK  = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_DIVX  = 10'b0001000000,
        S_DIVY  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_RD2   = 10'b1000000000
    } t_state;
endpackage

@@ rtl/wpfs_if.sv @@
interface wpfs_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  slot;
    logic signed [31:0] way_x;
    logic signed [31:0] way_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    modport source (output valid, action, slot, way_x, way_y, pos_x, pos_y, goal_x, goal_y,
                    input ready);
    modport sink (input valid, action, slot, way_x, way_y, pos_x, pos_y, goal_x, goal_y,
                  output ready);
endinterface

interface wpfs_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic        final_leg;
    logic [5:0]  current_waypoint;
    modport source (output valid, vel_x, vel_y, final_leg, current_waypoint, input ready);
    modport sink (input valid, vel_x, vel_y, final_leg, current_waypoint, output ready);
endinterface

interface wpfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/wpfs_ram.sv @@
module wpfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ rtl/waypoint_path_follow_steering_core.sv @@
// Waypoint follower with seek and arrive steering. A load transaction writes
// one waypoint and returns nothing, and the block stays ready. A steer
// transaction returns one result after a store read, a reach test, a second
// store read, a squared length on one shared 33x33 multiplier, then a
// shift-subtract square root of 34 steps and two 48-step divides, one bit a
// cycle. An empty path skips the rest, and a zero vector skips the divides.
// The block takes no input transaction while a steer is in work or its result
// waits, so a result held back by the receiver stalls the input.
// Slot 0 reads as origin until written.
module waypoint_path_follow_steering_core #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wpfs_in_if.sink   in_ch,
    wpfs_out_if.source out_ch,
    wpfs_cfg_if.sink  cfg_ch
);
    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int IW = AW + 1;

    wpfs_pkg::t_state r_state;

    logic [6:0]  r_count;
    logic [IW-1:0] r_idx;
    logic          r_w0;

    logic signed [31:0] r_px, r_py, r_gx, r_gy;
    logic signed [32:0] r_dx, r_dy;
    logic [66:0] r_sum;
    logic [1:0]  r_sq_ph;
    logic [66:0] r_rem;
    logic [33:0] r_root;
    logic [5:0]  r_bit;
    logic [47:0] r_num;
    logic [33:0] r_den;
    logic [47:0] r_q;
    logic [34:0] r_drem;
    logic        r_dstart;
    logic        r_fin;
    logic        r_zero;
    logic signed [15:0] r_vx_h, r_vy_h;
    logic        r_ovalid;

    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0] ram_rdata;

    logic in_fire, cfg_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign in_ch.ready  = (r_state == wpfs_pkg::S_IDLE) && !r_ovalid;
    assign cfg_ch.ready = 1'b1;

    assign ram_we    = in_fire && in_ch.action == wpfs_pkg::ActLoad
                       && (int'(in_ch.slot) < MAX_WAYPOINTS);
    assign ram_waddr = AW'(in_ch.slot);
    assign ram_raddr = r_idx[AW-1:0];

    wpfs_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr),
        .i_wdata({in_ch.way_x, in_ch.way_y}), .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // waypoint read, origin for slot zero until written
    logic signed [31:0] wx, wy;
    assign wx = (!r_w0 && r_idx == '0) ? 32'sd0 : $signed(ram_rdata[63:32]);
    assign wy = (!r_w0 && r_idx == '0) ? 32'sd0 : $signed(ram_rdata[31:0]);

    // shared multiplier operand select
    logic [32:0] mul_a;
    logic [65:0] mul_p;
    always_comb begin
        case (r_sq_ph)
            2'd0:    mul_a = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
            default: mul_a = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        endcase
    end
    assign mul_p = 66'(mul_a) * 66'(mul_a);

    // reach test on the current waypoint
    logic signed [32:0] rdx, rdy;
    logic [32:0] rax, ray;
    logic [33:0] rsum;
    logic        reached;
    logic [31:0] r_rr;
    assign rdx = 33'(wx) - 33'(r_px);
    assign rdy = 33'(wy) - 33'(r_py);
    assign rax = rdx[32] ? 33'(-rdx) : 33'(rdx);
    assign ray = rdy[32] ? 33'(-rdy) : 33'(rdy);
    // reach radius squared is below 2^32 so small deltas only
    assign rsum = 34'(32'(rax[15:0]) * 32'(rax[15:0]))
                  + 34'(32'(ray[15:0]) * 32'(ray[15:0]));
    assign reached = rax < 33'd65536 && ray < 33'd65536 && rsum < 34'(r_rr);

    // square root trial: (2r + 2^b) against remainder >> b
    logic [66:0] t_base;
    assign t_base = (67'(r_root) << 1) | (67'd1 << r_bit);

    logic [33:0] len_den;
    assign len_den = (r_fin && 34'(r_slow) > r_root) ? 34'(r_slow) : r_root;

    // divide step
    logic [34:0] d_sh;
    assign d_sh = {r_drem[33:0], r_num[47]};

    logic [23:0] r_slow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpfs_pkg::S_IDLE;
            r_count <= 7'd1;
            r_slow  <= 24'd25600;
            r_idx   <= '0;
            r_w0    <= 1'b0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_rr    <= 32'd1638400;
        end else begin
            if (cfg_fire) begin
                case (cfg_ch.index)
                    wpfs_pkg::RegPathCount: begin
                        r_count <= (int'(cfg_ch.data[6:0]) > MAX_WAYPOINTS)
                                   ? 7'(MAX_WAYPOINTS) : cfg_ch.data[6:0];
                        r_idx <= '0;
                    end
                    wpfs_pkg::RegReach: begin
                        r_rr <= 32'(cfg_ch.data[15:0]) * 32'(cfg_ch.data[15:0]);
                    end
                    wpfs_pkg::RegSlow: r_slow <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (ram_we && in_ch.slot == '0) r_w0 <= 1'b1;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                wpfs_pkg::S_IDLE: begin
                    if (in_fire && in_ch.action == wpfs_pkg::ActSteer) begin
                        r_px <= in_ch.pos_x; r_py <= in_ch.pos_y;
                        r_gx <= in_ch.goal_x; r_gy <= in_ch.goal_y;
                        r_state <= wpfs_pkg::S_RD;
                    end
                end
                wpfs_pkg::S_RD: r_state <= wpfs_pkg::S_REACH;
                wpfs_pkg::S_REACH: begin
                    if (r_count != '0 && 7'(r_idx) + 7'd1 < r_count && reached)
                        r_idx <= r_idx + IW'(1);
                    r_state <= wpfs_pkg::S_RD2;
                end
                wpfs_pkg::S_RD2: r_state <= wpfs_pkg::S_PICK;
                wpfs_pkg::S_PICK: begin
                    r_fin <= 1'b0; r_sq_ph <= 2'd0;
                    if (r_count == '0) begin
                        r_state <= wpfs_pkg::S_OUT;
                    end else if (7'(r_idx) + 7'd1 == r_count) begin
                        r_fin <= 1'b1;
                        r_dx <= 33'(r_gx) - 33'(r_px);
                        r_dy <= 33'(r_gy) - 33'(r_py);
                        r_state <= wpfs_pkg::S_SQ;
                    end else begin
                        r_dx <= rdx; r_dy <= rdy;
                        r_state <= wpfs_pkg::S_SQ;
                    end
                end
                wpfs_pkg::S_SQ: begin
                    r_sq_ph <= r_sq_ph + 2'd1;
                    if (r_sq_ph == 2'd0) r_sum <= 67'(mul_p);
                    else begin
                        r_sum <= r_sum + 67'(mul_p);
                        r_zero <= (r_dx == 0 && r_dy == 0);
                        r_state <= wpfs_pkg::S_SQRT;
                        r_root <= '0; r_bit <= 6'd33;
                        r_rem <= r_sum + 67'(mul_p);
                    end
                end
                wpfs_pkg::S_SQRT: begin
                    // restoring root: keep bit b when (r + 2^b)^2 fits the sum
                    if (t_base <= (r_rem >> r_bit)) begin
                        r_rem <= r_rem - (t_base << r_bit);
                        r_root <= r_root | (34'd1 << r_bit);
                    end
                    if (r_bit == 0) begin
                        r_state <= wpfs_pkg::S_DIVX;
                        r_bit <= 6'd47;
                        r_dstart <= 1'b1;
                    end else r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd33) begin
                        r_num <= '0; r_drem <= '0; r_q <= '0;
                    end
                end
                wpfs_pkg::S_DIVX, wpfs_pkg::S_DIVY: begin
                    if (r_dstart) begin
                        r_dstart <= 1'b0;
                        r_den <= len_den;
                        r_num <= ((48'(r_state == wpfs_pkg::S_DIVX
                                   ? (r_dx[32] ? 33'(-r_dx) : 33'(r_dx))
                                   : (r_dy[32] ? 33'(-r_dy) : 33'(r_dy)))) << 14)
                                 + 48'(len_den >> 1);
                        r_drem <= '0;
                        r_q <= '0;
                        r_bit <= 6'd48;
                        if (r_zero || len_den == 0) begin
                            r_state <= wpfs_pkg::S_OUT;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        if (d_sh >= 35'(r_den)) begin
                            r_drem <= d_sh - 35'(r_den);
                            r_q <= {r_q[46:0], 1'b1};
                        end else begin
                            r_drem <= d_sh;
                            r_q <= {r_q[46:0], 1'b0};
                        end
                        if (r_bit == 6'd1) begin
                            r_bit <= 6'd47; r_num <= '0; r_drem <= '0; r_q <= '0;
                            if (r_state == wpfs_pkg::S_DIVX) begin
                                r_dstart <= 1'b1;
                                r_state <= wpfs_pkg::S_DIVY;
                            end else r_state <= wpfs_pkg::S_OUT;
                        end else r_bit <= r_bit - 6'd1;
                    end
                end
                wpfs_pkg::S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= wpfs_pkg::S_IDLE;
                end
                default: r_state <= wpfs_pkg::S_IDLE;
            endcase
        end
    end

    // capture quotient with sign when the last divide bit lands
    logic [47:0] q_fin;
    assign q_fin = {r_q[46:0], (d_sh >= 35'(r_den))};
    always_ff @(posedge i_clk) begin
        if ((r_state == wpfs_pkg::S_DIVX || r_state == wpfs_pkg::S_DIVY)
            && !r_dstart && r_bit == 6'd1) begin
            if (r_state == wpfs_pkg::S_DIVX)
                r_vx_h <= r_dx[32] ? -16'(q_fin[15:0]) : 16'(q_fin[15:0]);
            else
                r_vy_h <= r_dy[32] ? -16'(q_fin[15:0]) : 16'(q_fin[15:0]);
        end
        if (r_state == wpfs_pkg::S_PICK) begin
            r_vx_h <= '0; r_vy_h <= '0;
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.vel_x = r_vx_h;
    assign out_ch.vel_y = r_vy_h;
    assign out_ch.final_leg = r_fin;
    assign out_ch.current_waypoint = 6'(r_idx);

    // the input is never ready while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> in_ch.ready == 1'b0) else $error("accept with result pending");
    // index stays inside the path
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> 7'(r_idx) < r_count) else $error("index out of path");
endmodule
